FILE: rtl/sdt_pkg.sv
// Shared types and constants for the skip-and-delimiter tokenizer.
// Used by every module of the block; depends on nothing.
package sdt_pkg;

  localparam int SET_SIZE    = 8;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int ADDR_W      = 6;

  localparam logic [63:0] SKIP_CHARS_RST  = 64'd657696;
  localparam logic [3:0]  SKIP_COUNT_RST  = 4'd3;
  localparam logic [63:0] DELIM_CHARS_RST = 64'd58;
  localparam logic [3:0]  DELIM_COUNT_RST = 4'd1;
  localparam logic [7:0]  MAX_FIELDS_RST  = 8'd16;

  typedef enum logic [2:0] {
    REG_SKIP_CHARS  = 3'd0,
    REG_SKIP_COUNT  = 3'd1,
    REG_DELIM_CHARS = 3'd2,
    REG_DELIM_COUNT = 3'd3,
    REG_MAX_FIELDS  = 3'd4
  } reg_idx_t;

  typedef enum logic {
    OP_CHAR = 1'b0,
    OP_END  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    KIND_CHAR = 2'd0,
    KIND_END  = 2'd1,
    KIND_DONE = 2'd2
  } kind_t;

  typedef enum logic [3:0] {
    MODE_LEAD  = 4'b0001,
    MODE_FIELD = 4'b0010,
    MODE_GAP   = 4'b0100,
    MODE_RAW   = 4'b1000
  } scan_mode_t;

  typedef struct packed {
    logic       op;
    logic [7:0] ch;
  } char_item_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] out_char;
    logic [7:0] field_index;
    logic [7:0] field_total;
    logic       overflow;
    logic       last;
  } tok_item_t;

  typedef struct packed {
    logic [63:0] skip_chars;
    logic [3:0]  skip_count;
    logic [63:0] delim_chars;
    logic [3:0]  delim_count;
    logic [7:0]  max_fields;
  } cfg_t;

  // One queue entry: a single result, or a field end followed by the done result
  typedef struct packed {
    kind_t      kind;
    logic [7:0] out_char;
    logic [7:0] field_index;
    logic [7:0] field_total;
    logic       overflow;
    logic       pair;
  } cmd_t;

endpackage

FILE: rtl/sdt_front.sv
// Front end of the tokenizer: accepts characters, matches them against both sets,
// tracks scan mode and field count, and queues result commands. Uses sdt_pkg.
module sdt_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               char_valid,
  output logic               char_stall,
  input  sdt_pkg::char_item_t char_data,
  input  sdt_pkg::cfg_t      cfg,
  input  logic               q_full,
  output logic               q_push,
  output sdt_pkg::cmd_t      q_data
);

  sdt_pkg::scan_mode_t scan_mode, scan_mode_next;
  logic [7:0]          field_counter, field_counter_next;
  logic                accept;
  logic                is_skip, is_delim;
  logic [7:0]          cap;
  logic                at_cap;
  logic                emit;

  function automatic logic in_set(logic [63:0] chars, logic [3:0] count, logic [7:0] c);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < sdt_pkg::SET_SIZE; i++) begin
      if ((count > 4'(i)) && (chars[8*i +: 8] == c)) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

  assign char_stall = q_full;
  assign accept     = char_valid && !q_full;
  assign is_skip    = in_set(cfg.skip_chars, cfg.skip_count, char_data.ch);
  assign is_delim   = in_set(cfg.delim_chars, cfg.delim_count, char_data.ch);
  assign cap        = (cfg.max_fields == 8'd0) ? 8'd0 : cfg.max_fields - 8'd1;
  assign at_cap     = field_counter >= cap;

  always_comb begin
    scan_mode_next       = scan_mode;
    field_counter_next   = field_counter;
    emit                 = 1'b0;
    q_data               = '0;
    q_data.kind          = sdt_pkg::KIND_CHAR;
    q_data.out_char      = char_data.ch;
    q_data.field_index   = field_counter;
    if (char_data.op == sdt_pkg::OP_END) begin
      emit               = 1'b1;
      q_data.out_char    = 8'd0;
      scan_mode_next     = sdt_pkg::MODE_LEAD;
      field_counter_next = 8'd0;
      if (scan_mode == sdt_pkg::MODE_FIELD || scan_mode == sdt_pkg::MODE_RAW) begin
        // close the open field, then report done
        q_data.kind        = sdt_pkg::KIND_END;
        q_data.pair        = 1'b1;
        q_data.field_total = field_counter + 8'd1;
        q_data.overflow    = (scan_mode == sdt_pkg::MODE_RAW) || at_cap;
      end else begin
        q_data.kind        = sdt_pkg::KIND_DONE;
        q_data.field_index = 8'd0;
        q_data.field_total = field_counter;
      end
    end else begin
      unique case (scan_mode)
        sdt_pkg::MODE_RAW: begin
          emit            = 1'b1;
          q_data.overflow = 1'b1;
        end
        sdt_pkg::MODE_FIELD: begin
          emit = 1'b1;
          if (is_delim || is_skip) begin
            if (at_cap) begin
              q_data.overflow = 1'b1;
              scan_mode_next  = sdt_pkg::MODE_RAW;
            end else begin
              q_data.kind        = sdt_pkg::KIND_END;
              q_data.out_char    = 8'd0;
              field_counter_next = field_counter + 8'd1;
              scan_mode_next     = is_delim ? sdt_pkg::MODE_LEAD : sdt_pkg::MODE_GAP;
            end
          end
        end
        sdt_pkg::MODE_GAP: begin
          if (is_delim) begin
            scan_mode_next = sdt_pkg::MODE_LEAD;
          end else if (!is_skip) begin
            emit           = 1'b1;
            scan_mode_next = sdt_pkg::MODE_FIELD;
          end
        end
        default: begin
          if (is_skip) begin
            emit = 1'b0;
          end else if (is_delim) begin
            emit = 1'b1;
            if (at_cap) begin
              q_data.overflow = 1'b1;
              scan_mode_next  = sdt_pkg::MODE_RAW;
            end else begin
              q_data.kind        = sdt_pkg::KIND_END;
              q_data.out_char    = 8'd0;
              field_counter_next = field_counter + 8'd1;
            end
          end else begin
            emit           = 1'b1;
            scan_mode_next = sdt_pkg::MODE_FIELD;
          end
        end
      endcase
    end
  end

  assign q_push = accept && emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode     <= sdt_pkg::MODE_LEAD;
      field_counter <= 8'd0;
    end else if (accept) begin
      scan_mode     <= scan_mode_next;
      field_counter <= field_counter_next;
    end
  end

`ifndef ASSERT_OFF
  // the counter stops at the last slot and never reaches 255
  assert property (@(posedge clk) disable iff (rst) field_counter != 8'hFF)
    else $error("field counter ran past the last slot");
  // the verbatim remainder is only entered when the limit was reached
  assert property (@(posedge clk) disable iff (rst)
    accept && scan_mode != sdt_pkg::MODE_RAW && scan_mode_next == sdt_pkg::MODE_RAW
    |-> at_cap && q_push && q_data.overflow)
    else $error("remainder merge without reaching the field limit");
`endif

endmodule

FILE: rtl/sdt_queue.sv
// Short command queue between tokenizer front and back ends.
// Register-based FIFO of sdt_pkg::cmd_t entries; uses sdt_pkg.
module sdt_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  sdt_pkg::cmd_t push_data,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output sdt_pkg::cmd_t head
);

  sdt_pkg::cmd_t                 entries [sdt_pkg::QUEUE_DEPTH];
  logic [sdt_pkg::QPTR_W-1:0]    wr_ptr, rd_ptr;
  logic [sdt_pkg::QCNT_W-1:0]    count;

  assign full       = count == sdt_pkg::QCNT_W'(sdt_pkg::QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == sdt_pkg::QPTR_W'(sdt_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == sdt_pkg::QPTR_W'(sdt_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

`ifndef ASSERT_OFF
  assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("push into a full queue");
  assert property (@(posedge clk) disable iff (rst) pop |-> head_valid)
    else $error("pop from an empty queue");
`endif

endmodule

FILE: rtl/sdt_back.sv
// Back end of the tokenizer: drains queued commands into the output register,
// splitting a paired command into field end and done. Uses sdt_pkg.
module sdt_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              head_valid,
  input  sdt_pkg::cmd_t     head,
  output logic              pop,
  output logic              tok_valid,
  input  logic              tok_stall,
  output sdt_pkg::tok_item_t tok_data
);

  logic               load, take, phase;
  sdt_pkg::tok_item_t result;

  assign load = !tok_valid || !tok_stall;
  assign take = load && head_valid;
  assign pop  = take && (!head.pair || phase);

  always_comb begin
    result.kind        = head.kind;
    result.out_char    = head.out_char;
    result.field_index = head.field_index;
    result.field_total = head.field_total;
    result.overflow    = head.overflow;
    result.last        = 1'b1;
    if (head.pair) begin
      if (phase) begin
        // second half: done result
        result.kind        = sdt_pkg::KIND_DONE;
        result.field_index = 8'd0;
      end else begin
        result.field_total = 8'd0;
        result.last        = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_valid <= 1'b0;
      phase     <= 1'b0;
    end else begin
      if (load) begin
        tok_valid <= head_valid;
      end
      if (take) begin
        phase <= head.pair && !phase;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      tok_data <= result;
    end
  end

`ifndef ASSERT_OFF
  // half of a pair is out: its entry stays at the head until the done goes out
  assert property (@(posedge clk) disable iff (rst) phase |-> head_valid && head.pair)
    else $error("pair split lost its queue entry");
  assert property (@(posedge clk) disable iff (rst)
    tok_valid && tok_data.kind == sdt_pkg::KIND_DONE |-> tok_data.last)
    else $error("done result not marked last");
`endif

endmodule

FILE: rtl/skip_and_delimiter_tokenizer.sv
// Top level of the skip-and-delimiter tokenizer: configuration registers and
// the front end, command queue and back end. Uses sdt_pkg, sdt_front, sdt_queue, sdt_back.

// Splits a character stream into fields, one character item per cycle. Bytes of
// the skip set separate fields and are dropped in runs; each byte of the delimiter
// set ends a field, so adjacent delimiters give empty fields. Once the field count
// reaches max_fields - 1, the rest of the string, separators included, is passed
// through as the last field with overflow set. An end-of-string item closes any
// open field and yields a done result carrying the field total. The front end
// takes one item per cycle whenever the four-entry command queue has room; the
// back end emits one result per cycle from its output register while tok_stall is
// low. An end of string that closes a field makes two results, a field end and
// then the done, from one queue entry; every other item makes at most one. An
// accepted item passes through the queue write, then the output register. Config
// lives in 64-bit registers at byte address 8*i: skip_chars, skip_count, delim_chars,
// delim_count, max_fields; write them only while the block is idle.
module skip_and_delimiter_tokenizer (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [sdt_pkg::ADDR_W-1:0] paddr,
  input  logic [63:0]                pwdata,
  output logic [63:0]                prdata,
  output logic                       pready,
  input  logic                       char_valid,
  output logic                       char_stall,
  input  sdt_pkg::char_item_t        char_data,
  output logic                       tok_valid,
  input  logic                       tok_stall,
  output sdt_pkg::tok_item_t         tok_data
);

  sdt_pkg::cfg_t     cfg;
  sdt_pkg::reg_idx_t reg_idx;
  logic              wr_en;
  logic              q_push, q_full, q_pop, q_head_valid;
  sdt_pkg::cmd_t     q_data, q_head;

  // Register index comes from the 8-byte word address
  assign reg_idx = sdt_pkg::reg_idx_t'(paddr[5:3]);
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.skip_chars  <= sdt_pkg::SKIP_CHARS_RST;
      cfg.skip_count  <= sdt_pkg::SKIP_COUNT_RST;
      cfg.delim_chars <= sdt_pkg::DELIM_CHARS_RST;
      cfg.delim_count <= sdt_pkg::DELIM_COUNT_RST;
      cfg.max_fields  <= sdt_pkg::MAX_FIELDS_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        sdt_pkg::REG_SKIP_CHARS:  cfg.skip_chars  <= pwdata;
        sdt_pkg::REG_SKIP_COUNT:  cfg.skip_count  <= pwdata[3:0];
        sdt_pkg::REG_DELIM_CHARS: cfg.delim_chars <= pwdata;
        sdt_pkg::REG_DELIM_COUNT: cfg.delim_count <= pwdata[3:0];
        sdt_pkg::REG_MAX_FIELDS:  cfg.max_fields  <= pwdata[7:0];
        default: ; // drop writes past the register list
      endcase
    end
  end

  // Read back the addressed register, zero-extended
  always_comb begin
    unique case (reg_idx)
      sdt_pkg::REG_SKIP_CHARS:  prdata = cfg.skip_chars;
      sdt_pkg::REG_SKIP_COUNT:  prdata = {60'd0, cfg.skip_count};
      sdt_pkg::REG_DELIM_CHARS: prdata = cfg.delim_chars;
      sdt_pkg::REG_DELIM_COUNT: prdata = {60'd0, cfg.delim_count};
      sdt_pkg::REG_MAX_FIELDS:  prdata = {56'd0, cfg.max_fields};
      default:                  prdata = 64'd0;
    endcase
  end

  // Classify and advance the scan state; hold input while the queue is full
  sdt_front u_front (
    .clk        (clk),
    .rst        (rst),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .char_data  (char_data),
    .cfg        (cfg),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_data     (q_data)
  );

  // Decouple the two sides so each can stall on its own
  sdt_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_data  (q_data),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head       (q_head)
  );

  // Emit results one per cycle through the output register while tok_stall is low
  sdt_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (q_head_valid),
    .head       (q_head),
    .pop        (q_pop),
    .tok_valid  (tok_valid),
    .tok_stall  (tok_stall),
    .tok_data   (tok_data)
  );

endmodule

FILE: tb/sv/skip_and_delimiter_tokenizer_tb.sv
// Self-checking testbench for the skip-and-delimiter tokenizer: directed script, then
// randomized strings under several register settings, with random idling on both sides.
// Depends on sdt_pkg and the skip_and_delimiter_tokenizer RTL only.
module skip_and_delimiter_tokenizer_tb;
  import sdt_pkg::*;

  localparam int CLK_PERIOD     = 12;
  localparam int RESET_CYCLES   = 6;
  localparam int TIMEOUT_CYCLES = 500_000;
  localparam int NUM_PHASES     = 10;
  localparam int PHASE_ITEMS    = 105;
  localparam int LONG_PHASE     = 5;    // max_fields at 255, one string long enough to merge
  localparam int LONG_RUN       = 300;
  localparam int DRAIN_CYCLES   = 8;

  typedef enum logic [1:0] {
    ROW_ITEM,     // send, expectation from the predictor
    ROW_CHECKED,  // send, single result typed into the script
    ROW_CFG       // wait for idle, then write a register
  } row_act_t;

  typedef struct {
    row_act_t    act;
    op_t         op;
    logic [7:0]  ch;
    reg_idx_t    rsel;
    logic [63:0] value;
    tok_item_t   want;
  } script_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [ADDR_W-1:0] paddr   = '0;
  logic [63:0]       pwdata  = '0;
  logic [63:0]       prdata;
  logic              pready;

  logic       char_valid = 1'b0;
  logic       char_stall;
  char_item_t char_data  = '0;
  logic       tok_valid;
  logic       tok_stall  = 1'b0;
  tok_item_t  tok_data;

  // Predictor copy of the registers and the scan state
  logic [63:0] cfg_skip_chars  = SKIP_CHARS_RST;
  logic [3:0]  cfg_skip_count  = SKIP_COUNT_RST;
  logic [63:0] cfg_delim_chars = DELIM_CHARS_RST;
  logic [3:0]  cfg_delim_count = DELIM_COUNT_RST;
  logic [7:0]  cfg_max_fields  = MAX_FIELDS_RST;
  scan_mode_t  scan            = MODE_LEAD;
  logic [7:0]  field_count     = '0;

  tok_item_t   step_tokens[$];      // results of the item just accepted
  tok_item_t   expected_tokens[$];  // results still owed by the block
  script_row_t script[$];

  bit idle_on        = 1'b1;
  int stall_hold     = 0;
  int mismatch_count = 0;
  int items_sent     = 0;
  int strings_sent   = 0;
  int tokens_checked = 0;
  int settings_used  = 1;

  skip_and_delimiter_tokenizer DUT (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .char_data  (char_data),
    .tok_valid  (tok_valid),
    .tok_stall  (tok_stall),
    .tok_data   (tok_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Counts above the set size act as the full set
  function automatic int set_len(logic [3:0] n);
    return (n > SET_SIZE) ? SET_SIZE : int'(n);
  endfunction

  function automatic bit in_set(logic [63:0] chars, logic [3:0] count, logic [7:0] c);
    int lim;
    bit hit;
    lim = set_len(count);
    hit = 1'b0;
    for (int i = 0; i < lim; i++)
      if (chars[8*i +: 8] == c) hit = 1'b1;
    return hit;
  endfunction

  function automatic tok_item_t tok(kind_t k, logic [7:0] c, logic [7:0] idx,
                                    logic [7:0] total, bit ovf, bit fin);
    tok_item_t t;
    t.kind        = k;
    t.out_char    = c;
    t.field_index = idx;
    t.field_total = total;
    t.overflow    = ovf;
    t.last        = fin;
    return t;
  endfunction

  // Advance the scan state by one item and leave its results in step_tokens
  task automatic predict_tokens(input op_t op, input logic [7:0] c);
    int         cap;
    bit         at_cap;
    bit         sk;
    bit         dl;
    bit         ovf;
    logic [7:0] total;
    step_tokens.delete();
    // zero slots behave as one
    cap    = ((cfg_max_fields == 0) ? 1 : int'(cfg_max_fields)) - 1;
    at_cap = int'(field_count) >= cap;
    sk     = in_set(cfg_skip_chars, cfg_skip_count, c);
    dl     = in_set(cfg_delim_chars, cfg_delim_count, c);
    if (op == OP_END) begin
      total = field_count;
      ovf   = 1'b0;
      if (scan == MODE_FIELD || scan == MODE_RAW) begin
        // close the open field; a merged remainder always carries overflow
        ovf   = (scan == MODE_RAW) ? 1'b1 : at_cap;
        step_tokens.push_back(tok(KIND_END, 8'd0, field_count, 8'd0, ovf, 1'b0));
        total = field_count + 8'd1;
      end
      step_tokens.push_back(tok(KIND_DONE, 8'd0, 8'd0, total, ovf, 1'b0));
      scan        = MODE_LEAD;
      field_count = '0;
    end else begin
      case (scan)
        MODE_RAW: begin
          step_tokens.push_back(tok(KIND_CHAR, c, field_count, 8'd0, 1'b1, 1'b0));
        end
        MODE_FIELD: begin
          if (dl || sk) begin
            if (at_cap) begin
              step_tokens.push_back(tok(KIND_CHAR, c, field_count, 8'd0, 1'b1, 1'b0));
              scan = MODE_RAW;
            end else begin
              step_tokens.push_back(tok(KIND_END, 8'd0, field_count, 8'd0, 1'b0, 1'b0));
              field_count = field_count + 8'd1;
              scan        = dl ? MODE_LEAD : MODE_GAP;
            end
          end else begin
            step_tokens.push_back(tok(KIND_CHAR, c, field_count, 8'd0, 1'b0, 1'b0));
          end
        end
        MODE_GAP: begin
          // a delimiter right after a skip run does not open an empty field
          if (dl) begin
            scan = MODE_LEAD;
          end else if (!sk) begin
            step_tokens.push_back(tok(KIND_CHAR, c, field_count, 8'd0, 1'b0, 1'b0));
            scan = MODE_FIELD;
          end
        end
        default: begin
          // leading or after a delimiter: skip wins over delimiter here
          if (!sk) begin
            if (dl && at_cap) begin
              step_tokens.push_back(tok(KIND_CHAR, c, field_count, 8'd0, 1'b1, 1'b0));
              scan = MODE_RAW;
            end else if (dl) begin
              step_tokens.push_back(tok(KIND_END, 8'd0, field_count, 8'd0, 1'b0, 1'b0));
              field_count = field_count + 8'd1;
            end else begin
              step_tokens.push_back(tok(KIND_CHAR, c, field_count, 8'd0, 1'b0, 1'b0));
              scan = MODE_FIELD;
            end
          end
        end
      endcase
    end
    if (step_tokens.size() != 0) step_tokens[step_tokens.size() - 1].last = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Setup-then-access register write; the predictor copy follows once the access completes
  task automatic cfg_write(input reg_idx_t r, input logic [63:0] v);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({r, 3'b000});
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (r)
      REG_SKIP_CHARS:  cfg_skip_chars  = v;
      REG_SKIP_COUNT:  cfg_skip_count  = v[3:0];
      REG_DELIM_CHARS: cfg_delim_chars = v;
      REG_DELIM_COUNT: cfg_delim_count = v[3:0];
      default:         cfg_max_fields  = v[7:0];
    endcase
  endtask

  // Drop valid, let every owed result arrive, then cover items still in flight
  task automatic settle_idle();
    char_valid <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Offer one item, hold it until accepted, then queue what it should produce
  task automatic send_item(input op_t op, input logic [7:0] c, input bit typed,
                           input tok_item_t want);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      char_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    char_valid <= 1'b1;
    char_data  <= {op, c};
    do @(posedge clk); while (char_stall);
    predict_tokens(op, c);
    if (typed) begin
      expected_tokens.push_back(want);
    end else begin
      foreach (step_tokens[k]) expected_tokens.push_back(step_tokens[k]);
    end
    items_sent++;
  endtask

  // ---------------------------------------------------------------------------
  // Random content
  // ---------------------------------------------------------------------------

  // Separator candidates lean on a small pool so that the two sets overlap often
  function automatic logic [7:0] pick_set_byte();
    logic [7:0] pool[8];
    pool = '{8'h20, 8'h2C, 8'h3A, 8'h3B, 8'h09, 8'h61, 8'h00, 8'hFF};
    if ($urandom_range(0, 3) == 0) return 8'($urandom_range(0, 255));
    return pool[$urandom_range(0, 7)];
  endfunction

  function automatic logic [63:0] random_set();
    logic [63:0] s;
    for (int i = 0; i < 8; i++) s[8*i +: 8] = pick_set_byte();
    return s;
  endfunction

  // Mostly separators of the current settings and a few letters, now and then any byte
  function automatic logic [7:0] pick_char();
    int r;
    int sc;
    int dc;
    r  = $urandom_range(0, 99);
    sc = set_len(cfg_skip_count);
    dc = set_len(cfg_delim_count);
    if (r < 35 && sc > 0) return cfg_skip_chars[8*$urandom_range(0, sc - 1) +: 8];
    if (r < 60 && dc > 0) return cfg_delim_chars[8*$urandom_range(0, dc - 1) +: 8];
    if (r < 95) return 8'h61 + 8'($urandom_range(0, 5));
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic play_string(input int len, input bit close);
    for (int i = 0; i < len; i++) send_item(OP_CHAR, pick_char(), 1'b0, '0);
    // the byte beside an end of string must be ignored, so make it random
    if (close) send_item(OP_END, 8'($urandom_range(0, 255)), 1'b0, '0);
    strings_sent++;
  endtask

  // One register setting per phase; the first few pin the extremes
  task automatic program_phase(input int p);
    logic [63:0] skip_v;
    logic [63:0] delim_v;
    logic [3:0]  skip_n;
    logic [3:0]  delim_n;
    logic [7:0]  max_v;
    skip_v  = (p == 0) ? 64'd0 : (p == 1) ? {64{1'b1}} : random_set();
    delim_v = random_set();
    skip_n  = (p == 0 || p == 1) ? 4'd8 : (p == 2 || p == LONG_PHASE) ? 4'd0 :
              (p == 3) ? 4'd15 : 4'($urandom_range(0, 8));
    delim_n = (p == 2) ? 4'd0 : (p == 3) ? 4'd9 :
              (p == LONG_PHASE) ? 4'($urandom_range(1, 8)) : 4'($urandom_range(0, 8));
    if (p == 4) max_v = 8'd1;
    else if (p == LONG_PHASE) max_v = 8'd255;
    else if (p == 6) max_v = 8'd0;
    else if ($urandom_range(0, 3) == 0) max_v = 8'($urandom_range(2, 40));
    else max_v = 8'($urandom_range(1, 5));
    cfg_write(REG_SKIP_CHARS, skip_v);
    cfg_write(REG_SKIP_COUNT, {60'd0, skip_n});
    cfg_write(REG_DELIM_CHARS, delim_v);
    cfg_write(REG_DELIM_COUNT, {60'd0, delim_n});
    cfg_write(REG_MAX_FIELDS, {56'd0, max_v});
    settings_used++;
  endtask

  // ---------------------------------------------------------------------------
  // Directed script
  // ---------------------------------------------------------------------------

  function automatic script_row_t item_row(op_t op, logic [7:0] c);
    script_row_t s;
    s.act   = ROW_ITEM;
    s.op    = op;
    s.ch    = c;
    s.rsel  = REG_SKIP_CHARS;
    s.value = '0;
    s.want  = '0;
    return s;
  endfunction

  function automatic script_row_t checked_row(op_t op, logic [7:0] c, tok_item_t want);
    script_row_t s;
    s      = item_row(op, c);
    s.act  = ROW_CHECKED;
    s.want = want;
    return s;
  endfunction

  function automatic script_row_t cfg_row(reg_idx_t r, logic [63:0] v);
    script_row_t s;
    s       = item_row(OP_CHAR, 8'd0);
    s.act   = ROW_CFG;
    s.rsel  = r;
    s.value = v;
    return s;
  endfunction

  task automatic load_script();
    // Reset settings: skip space, tab, newline; delimiter colon; sixteen slots.
    // Empty string straight after reset: a lone done with total zero.
    script.push_back(checked_row(OP_END, 8'h00, tok(KIND_DONE, 8'd0, 8'd0, 8'd0, 1'b0, 1'b1)));
    script.push_back(item_row(OP_CHAR, 8'h20));  // leading skip, dropped
    script.push_back(checked_row(OP_CHAR, 8'h61,
                                 tok(KIND_CHAR, 8'h61, 8'd0, 8'd0, 1'b0, 1'b1)));
    script.push_back(checked_row(OP_CHAR, 8'hFF,
                                 tok(KIND_CHAR, 8'hFF, 8'd0, 8'd0, 1'b0, 1'b1)));
    script.push_back(checked_row(OP_CHAR, 8'h20,
                                 tok(KIND_END, 8'd0, 8'd0, 8'd0, 1'b0, 1'b1)));
    script.push_back(item_row(OP_CHAR, 8'h3A));  // delimiter after a skip run, dropped
    script.push_back(checked_row(OP_CHAR, 8'h3A,
                                 tok(KIND_END, 8'd0, 8'd1, 8'd0, 1'b0, 1'b1)));
    // byte zero is an ordinary character
    script.push_back(checked_row(OP_CHAR, 8'h00,
                                 tok(KIND_CHAR, 8'h00, 8'd2, 8'd0, 1'b0, 1'b1)));
    script.push_back(item_row(OP_END, 8'hFF));
    // Two slots: the second separator merges the rest, separators included
    script.push_back(cfg_row(REG_MAX_FIELDS, 64'd2));
    script.push_back(item_row(OP_CHAR, 8'h78));
    script.push_back(item_row(OP_CHAR, 8'h3A));
    script.push_back(item_row(OP_CHAR, 8'h79));
    script.push_back(item_row(OP_CHAR, 8'h20));
    script.push_back(item_row(OP_CHAR, 8'h3A));
    script.push_back(item_row(OP_END, 8'h00));
    // Space in both sets, full delimiter set with all-ones bytes, zero slots
    script.push_back(cfg_row(REG_DELIM_CHARS, 64'hFFFF_FFFF_FFFF_FF20));
    script.push_back(cfg_row(REG_DELIM_COUNT, 64'd8));
    script.push_back(cfg_row(REG_MAX_FIELDS, 64'd0));
    script.push_back(item_row(OP_CHAR, 8'h20));  // leading: acts as a skip
    script.push_back(item_row(OP_CHAR, 8'h62));
    script.push_back(checked_row(OP_CHAR, 8'h20,
                                 tok(KIND_CHAR, 8'h20, 8'd0, 8'd0, 1'b1, 1'b1)));
    script.push_back(item_row(OP_END, 8'h00));
    // Most slots, then the limit lowered in the middle of a string
    script.push_back(cfg_row(REG_MAX_FIELDS, 64'd255));
    script.push_back(item_row(OP_CHAR, 8'h63));
    script.push_back(item_row(OP_CHAR, 8'h20));  // inside a field: acts as a delimiter
    script.push_back(item_row(OP_CHAR, 8'hFF));
    script.push_back(cfg_row(REG_MAX_FIELDS, 64'd1));
    script.push_back(item_row(OP_CHAR, 8'h64));
    script.push_back(item_row(OP_CHAR, 8'h09));
    script.push_back(item_row(OP_END, 8'h00));
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stall bursts, and the checker
  // ---------------------------------------------------------------------------

  // Alternate runs of free flow with stall bursts
  always @(posedge clk) begin
    if (rst || !idle_on) begin
      tok_stall  <= 1'b0;
      stall_hold <= 0;
    end else if (stall_hold != 0) begin
      stall_hold <= stall_hold - 1;
    end else if ($urandom_range(0, 3) == 0) begin
      tok_stall  <= 1'b1;
      stall_hold <= $urandom_range(0, 16);
    end else begin
      tok_stall  <= 1'b0;
      stall_hold <= $urandom_range(0, 20);
    end
  end

  task automatic report_field(input string fld, input logic [7:0] want, input logic [7:0] got);
    $display("%0t: %s mismatch: expected %0h, actual %0h", $time, fld, want, got);
    mismatch_count++;
  endtask

  // Compare each accepted result with the oldest owed one
  always @(posedge clk) begin
    tok_item_t want;
    if (!rst && tok_valid && !tok_stall) begin
      if (expected_tokens.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual %h", $time, tok_data);
        mismatch_count++;
      end else begin
        want = expected_tokens.pop_front();
        if (tok_data.kind !== want.kind) report_field("kind", want.kind, tok_data.kind);
        if (tok_data.out_char !== want.out_char)
          report_field("out_char", want.out_char, tok_data.out_char);
        if (tok_data.field_index !== want.field_index)
          report_field("field_index", want.field_index, tok_data.field_index);
        if (tok_data.field_total !== want.field_total)
          report_field("field_total", want.field_total, tok_data.field_total);
        if (tok_data.overflow !== want.overflow)
          report_field("overflow", want.overflow, tok_data.overflow);
        if (tok_data.last !== want.last) report_field("last", want.last, tok_data.last);
        tokens_checked++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    int len;
    int budget_end;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Walk the directed script
    load_script();
    foreach (script[i]) begin
      case (script[i].act)
        ROW_CFG: begin
          settle_idle();
          cfg_write(script[i].rsel, script[i].value);
        end
        ROW_CHECKED: send_item(script[i].op, script[i].ch, 1'b1, script[i].want);
        default:     send_item(script[i].op, script[i].ch, 1'b0, '0);
      endcase
    end
    strings_sent += 5;

    // Random phases; the last one runs with no idling on either side
    for (int p = 0; p < NUM_PHASES; p++) begin
      settle_idle();
      program_phase(p);
      idle_on = (p != NUM_PHASES - 1);
      if (p == LONG_PHASE) begin
        // Close whatever is open, then run enough delimiters to hit the slot limit
        send_item(OP_END, 8'h00, 1'b0, '0);
        for (int i = 0; i < LONG_RUN; i++)
          send_item(OP_CHAR, cfg_delim_chars[7:0], 1'b0, '0);
        send_item(OP_END, 8'h00, 1'b0, '0);
        strings_sent++;
      end
      budget_end = items_sent + PHASE_ITEMS;
      while (items_sent < budget_end) begin
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : $urandom_range(4, 24);
        // now and then leave a string open across the next one
        play_string(len, $urandom_range(0, 15) != 0);
      end
    end

    // Drain, then give late or extra results time to show up
    char_valid <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d items in %0d strings under %0d register settings;", items_sent,
             strings_sent, settings_used);
    $display("checked %0d results, %0d mismatches.", tokens_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog for a hung handshake
  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("%0t: timeout with %0d results still owed", $time, expected_tokens.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
